// ===== src/set_pkg.sv =====
package set_pkg;

	localparam int WinLen   = 50;
	localparam int SampleW  = 16;
	localparam int LenW     = 13;
	localparam int ShiftW   = 5;
	localparam int WeightW  = 8;
	localparam int CountW   = 8;
	localparam int OffW     = 3;
	localparam int CfgAddrW = 3;
	localparam int IdxW     = 14;
	localparam int ValOutW  = 29;
	localparam int RefOutW  = 41;

	localparam int SumW   = $clog2(WinLen * (2 ** (SampleW - 1)) + 1);
	localparam int WvRawW = SumW + WeightW;
	localparam int WvW    = (WvRawW > ValOutW) ? WvRawW : ValOutW;
	localparam int AccRaw = WvW + LenW + 1;
	localparam int AccW   = (AccRaw > RefOutW) ? AccRaw : RefOutW;

	localparam logic [IdxW-1:0] IdxDone = '1;

	localparam logic [CfgAddrW-1:0] CFG_LEARN_LEN       = 3'd0;
	localparam logic [CfgAddrW-1:0] CFG_THRESHOLD_SHIFT = 3'd1;
	localparam logic [CfgAddrW-1:0] CFG_DIFF_WEIGHT     = 3'd2;
	localparam logic [CfgAddrW-1:0] CFG_PRE_COUNT_MIN   = 3'd3;
	localparam logic [CfgAddrW-1:0] CFG_TRIG_COUNT_MIN  = 3'd4;
	localparam logic [CfgAddrW-1:0] CFG_OFF_SHIFT       = 3'd5;

	localparam logic [LenW-1:0]    RstLearnLen  = 13'd1000;
	localparam logic [ShiftW-1:0]  RstThrShift  = 5'd9;
	localparam logic [WeightW-1:0] RstWeight    = 8'd50;
	localparam logic [CountW-1:0]  RstPreMin    = 8'd6;
	localparam logic [CountW-1:0]  RstTrigMin   = 8'd50;
	localparam logic [OffW-1:0]    RstOffShift  = 3'd1;

	typedef enum logic [1:0] {
		PH_FILL   = 2'd0,
		PH_LEARN  = 2'd1,
		PH_DETECT = 2'd2
	} phase_t;

	typedef struct packed {
		logic [LenW-1:0]    learn_len;
		logic [ShiftW-1:0]  threshold_shift;
		logic [WeightW-1:0] diff_weight;
		logic [CountW-1:0]  pre_count_min;
		logic [CountW-1:0]  trig_count_min;
		logic [OffW-1:0]    off_shift;
	} cfg_t;

	typedef struct packed {
		logic [WvW-1:0]    wv;
		logic              window_valid;
		phase_t            phase;
		logic [AccW-1:0]   reference;
		logic [CountW-1:0] run_count;
		logic              event_res;
		logic              recording;
	} res_t;

endpackage

// ===== src/set_window.sv =====
module set_window import set_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  logic signed [SampleW-1:0] sample,
	output logic [SumW-1:0]           abs_sum,
	output logic [SumW-1:0]           diff_sum
);

	logic signed [SampleW-1:0] win_q [WinLen];
	logic signed [SampleW-1:0] departed_q;
	logic [SumW-1:0]           abs_sum_s2;
	logic [SumW-1:0]           diff_sum_s2;
	logic [SampleW-1:0]        mag_new;
	logic [SampleW-1:0]        mag_old;
	logic [SampleW-1:0]        mag_last;
	logic [SampleW-1:0]        mag_dep;
	logic [SumW-1:0]           abs_nxt;
	logic [SumW-1:0]           diff_nxt;

	function automatic logic [SampleW-1:0] mag(input logic signed [SampleW-1:0] v);
		mag = v[SampleW-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic [SampleW-1:0] adiff(input logic [SampleW-1:0] a,
		input logic [SampleW-1:0] b);
		adiff = (a > b) ? (a - b) : (b - a);
	endfunction

	always_comb begin
		mag_new  = mag(sample);
		mag_old  = mag(win_q[0]);
		mag_last = mag(win_q[WinLen-1]);
		mag_dep  = mag(departed_q);
		abs_nxt  = abs_sum_s2 - SumW'(mag_old) + SumW'(mag_new);
		diff_nxt = diff_sum_s2 - SumW'(adiff(mag_dep, mag_old))
			+ SumW'(adiff(mag_last, mag_new));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WinLen; i++) begin
				win_q[i] <= '0;
			end
			departed_q  <= '0;
			abs_sum_s2  <= '0;
			diff_sum_s2 <= '0;
		end else if (load) begin
			for (int i = 0; i < WinLen - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[WinLen-1] <= sample;
			departed_q      <= win_q[0];
			abs_sum_s2      <= abs_nxt;
			diff_sum_s2     <= diff_nxt;
		end
	end

	assign abs_sum  = abs_sum_s2;
	assign diff_sum = diff_sum_s2;

endmodule

// ===== src/set_detect.sv =====
module set_detect import set_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  logic [WvW-1:0] wv,
	input  cfg_t           cfg,
	output res_t           res
);

	logic [IdxW-1:0]   idx_q;
	logic [AccW-1:0]   acc_q;
	logic [AccW-1:0]   ref_q;
	logic [CountW-1:0] cnt_q;
	logic              rec_q;
	logic [WvW-1:0]    wv_s4;
	logic              valid_s4;
	phase_t            phase_s4;
	logic              event_s4;

	logic [IdxW-1:0]   idx_n;
	logic [AccW-1:0]   acc_n;
	logic [AccW-1:0]   ref_n;
	logic [CountW-1:0] cnt_n;
	logic              rec_n;
	logic              vld;
	phase_t            ph;
	logic              ev;
	logic              rose;
	logic [IdxW-1:0]   last;
	logic              at_last;
	logic [CountW-1:0] need;
	logic [AccW-1:0]   wv_ext;
	logic [AccW-1:0]   acc_sum;
	logic [AccW-1:0]   off_lvl;

	always_comb begin
		idx_n   = idx_q;
		acc_n   = acc_q;
		ref_n   = ref_q;
		cnt_n   = cnt_q;
		rec_n   = rec_q;
		vld     = 1'b0;
		ph      = PH_FILL;
		ev      = 1'b0;
		rose    = 1'b0;
		last    = IdxW'(WinLen - 1) + IdxW'(cfg.learn_len);
		at_last = (idx_q >= last);
		need    = (cfg.pre_count_min > cfg.trig_count_min) ? cfg.pre_count_min
			: cfg.trig_count_min;
		if (need == '0) begin
			need = CountW'(1);
		end
		wv_ext  = AccW'(wv);
		acc_sum = acc_q + (at_last ? (wv_ext << 1) : wv_ext);
		off_lvl = ref_q >> cfg.off_shift;

		priority if (idx_q < IdxW'(WinLen - 1)) begin
			idx_n = idx_q + 1'b1;
		end else if (idx_q == IdxW'(WinLen - 1)) begin
			vld   = 1'b1;
			idx_n = idx_q + 1'b1;
		end else if (idx_q != IdxDone) begin
			vld   = 1'b1;
			ph    = PH_LEARN;
			acc_n = acc_sum;
			if (at_last) begin
				ref_n = acc_sum >> cfg.threshold_shift;
				idx_n = IdxDone;
			end else begin
				idx_n = idx_q + 1'b1;
			end
		end else begin
			vld = 1'b1;
			ph  = PH_DETECT;
			if (wv_ext >= ref_q) begin
				if (cnt_q != '1) begin
					cnt_n = cnt_q + 1'b1;
					rose  = 1'b1;
				end
			end else begin
				cnt_n = '0;
			end
			if (rose && cnt_n == need) begin
				ev    = 1'b1;
				rec_n = 1'b1;
			end
			if (rec_n && wv_ext <= off_lvl) begin
				rec_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			acc_q    <= '0;
			ref_q    <= '0;
			cnt_q    <= '0;
			rec_q    <= 1'b0;
			valid_s4 <= 1'b0;
			phase_s4 <= PH_FILL;
			event_s4 <= 1'b0;
		end else if (load) begin
			idx_q    <= idx_n;
			acc_q    <= acc_n;
			ref_q    <= ref_n;
			cnt_q    <= cnt_n;
			rec_q    <= rec_n;
			valid_s4 <= vld;
			phase_s4 <= ph;
			event_s4 <= ev;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			wv_s4 <= vld ? wv : '0;
		end
	end

	always_comb begin
		res.wv           = wv_s4;
		res.window_valid = valid_s4;
		res.phase        = phase_s4;
		res.reference    = ref_q;
		res.run_count    = cnt_q;
		res.event_res    = event_s4;
		res.recording    = rec_q;
	end

`ifndef SYNTHESIS
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q == IdxDone |=> idx_q == IdxDone)
		else $error("learning done mark left");
	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != IdxDone |-> cnt_q == '0 && !rec_q)
		else $error("count or recording active before detection");
`endif

endmodule

// ===== src/seismic_event_trigger_top.sv =====
// Seismic event trigger, one signed 16-bit sample per input beat.
// Input channel: sample with in_valid/in_ready. Output channel: one result beat
// per input beat with out_valid/out_ready, carrying the window value, phase,
// learned reference level, consecutive count, event pulse and recording flag.
// Configuration: cfg_wen writes cfg_wdata into the register at cfg_addr in the
// same edge; write only while no beat is in flight.
// Path: an accepted beat passes the input register, the running-sum stage, the
// window-value multiply stage and the result register, then shows on out_valid.
// Throughput: one beat per cycle while out_ready stays high, set by the
// combinational update of the running sums and of the learning/detection state.
// Stall: each stage holds while the one after it is full and stalled; empty
// stages still fill, so up to four beats are held before in_ready drops.
// Reset: arst_n clears the sample window, sums, learning state and count, and
// loads the configuration defaults; the window then refills over the first
// 50 beats, after which learning runs for learn_len beats.
module seismic_event_trigger_top import set_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [SampleW-1:0] sample,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [ValOutW-1:0]        window_value,
	output logic                      window_valid,
	output logic [1:0]                phase,
	output logic [RefOutW-1:0]        reference_level,
	output logic [CountW-1:0]         run_count,
	output logic                      event_res,
	output logic                      recording,
	input  logic                      cfg_wen,
	input  logic [CfgAddrW-1:0]       cfg_addr,
	input  logic [LenW-1:0]           cfg_wdata
);

	cfg_t                      cfg_q;
	logic                      v1_q;
	logic                      v2_q;
	logic                      v3_q;
	logic                      v4_q;
	logic signed [SampleW-1:0] sample_s1;
	logic [WvW-1:0]            wv_s3;
	logic [SumW-1:0]           abs_sum;
	logic [SumW-1:0]           diff_sum;
	logic                      load2;
	logic                      load3;
	logic                      load4;
	res_t                      res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.learn_len       <= RstLearnLen;
			cfg_q.threshold_shift <= RstThrShift;
			cfg_q.diff_weight     <= RstWeight;
			cfg_q.pre_count_min   <= RstPreMin;
			cfg_q.trig_count_min  <= RstTrigMin;
			cfg_q.off_shift       <= RstOffShift;
		end else if (cfg_wen) begin
			unique case (cfg_addr)
				CFG_LEARN_LEN:       cfg_q.learn_len       <= cfg_wdata;
				CFG_THRESHOLD_SHIFT: cfg_q.threshold_shift <= cfg_wdata[ShiftW-1:0];
				CFG_DIFF_WEIGHT:     cfg_q.diff_weight     <= cfg_wdata[WeightW-1:0];
				CFG_PRE_COUNT_MIN:   cfg_q.pre_count_min   <= cfg_wdata[CountW-1:0];
				CFG_TRIG_COUNT_MIN:  cfg_q.trig_count_min  <= cfg_wdata[CountW-1:0];
				CFG_OFF_SHIFT:       cfg_q.off_shift       <= cfg_wdata[OffW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		load4    = v3_q && (!v4_q || out_ready);
		load3    = v2_q && (!v3_q || load4);
		load2    = v1_q && (!v2_q || load3);
		in_ready = !v1_q || load2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				v1_q <= 1'b1;
			end else if (load2) begin
				v1_q <= 1'b0;
			end
			if (load2) begin
				v2_q <= 1'b1;
			end else if (load3) begin
				v2_q <= 1'b0;
			end
			if (load3) begin
				v3_q <= 1'b1;
			end else if (load4) begin
				v3_q <= 1'b0;
			end
			if (load4) begin
				v4_q <= 1'b1;
			end else if (out_ready) begin
				v4_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= sample;
		end
		if (load3) begin
			wv_s3 <= WvW'(abs_sum) + WvW'(cfg_q.diff_weight) * WvW'(diff_sum);
		end
	end

	set_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load2),
		.sample   (sample_s1),
		.abs_sum  (abs_sum),
		.diff_sum (diff_sum)
	);

	set_detect u_detect (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load4),
		.wv     (wv_s3),
		.cfg    (cfg_q),
		.res    (res)
	);

	assign out_valid       = v4_q;
	assign window_value    = res.wv[ValOutW-1:0];
	assign window_valid    = res.window_valid;
	assign phase           = res.phase;
	assign reference_level = res.reference[RefOutW-1:0];
	assign run_count       = res.run_count;
	assign event_res       = res.event_res;
	assign recording       = res.recording;

`ifndef SYNTHESIS
	a_fill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !window_valid |-> window_value == '0 && phase == PH_FILL)
		else $error("window value shown before window full");
	a_event_detect: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res |-> phase == PH_DETECT && run_count != '0)
		else $error("event outside detection");
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v1_q && v2_q && v3_q && v4_q)
		else $error("input stalled with an empty stage");
`endif

endmodule
